>>> sv/point_camera_projector_assert.svh
// Assertion macros for the point camera projector checker
`ifndef POINT_CAMERA_PROJECTOR_ASSERT_SVH
`define POINT_CAMERA_PROJECTOR_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define PCP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("point projector check failed");

// next-cycle implication
`define PCP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("point projector check failed");

`endif

>>> sv/pcp_pkg.sv
// Shared constants and types for the point camera projector
package pcp_pkg;

    localparam int MAX_IMAGE_SIZE = 8192;
    localparam int PIX_W          = $clog2(MAX_IMAGE_SIZE);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_X     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_READY = 4'd7;

    localparam int C_W  = 34;
    localparam int M_W  = 59;
    localparam int N_W  = 60;
    localparam int D_W  = 41;
    localparam int R_W  = D_W + PIX_W;
    localparam int Z_W  = 27;

    localparam logic signed [C_W-1:0] NEAR_LIMIT = 34'sd163840;
    localparam logic [Z_W-1:0]        RAMP_DEPTH = 27'd98304000;
    localparam logic signed [15:0]    Z_FLOOR    = -16'sd150;
    localparam logic [22:0]           RECIP_6000 = 23'd5726623;
    localparam logic [12:0]           DIV_6000   = 13'd6000;

    localparam logic [2:0] RADIUS_LIDAR = 3'd1;
    localparam logic [2:0] RADIUS_RADAR = 3'd4;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [2:0] radius;
    } t_col;

endpackage

>>> sv/pcp_if.sv
// Point, pixel and configuration channel interfaces
interface pcp_pt_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               from_lidar;
    modport source (output valid, point_x, point_y, point_z, from_lidar, input ready);
    modport sink   (input valid, point_x, point_y, point_z, from_lidar, output ready);
endinterface

interface pcp_px_if;
    logic        valid;
    logic        ready;
    logic [12:0] pixel_u;
    logic [12:0] pixel_v;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [2:0]  dot_radius;
    modport source (output valid, pixel_u, pixel_v, blue, green, red, dot_radius,
                    input ready);
    modport sink   (input valid, pixel_u, pixel_v, blue, green, red, dot_radius,
                    output ready);
endinterface

interface pcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/point_camera_projector.sv
// Point camera projector: rigid transform, pinhole projection and dot colour
// Takes one item per cycle while the pixel side does not stall.
// Five arithmetic stages, then a 13-stage restoring divider, one quotient bit per stage.
// A stall on the pixel side holds the whole pipeline; dropped points leave bubbles.
// Synchronous active-low reset clears valid bits and loads the register reset values.
module point_camera_projector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcp_pt_if.sink     i_pt,
    pcp_px_if.source   o_px,
    pcp_cfg_if.sink    i_cfg
);
    import pcp_pkg::*;

    logic [63:0]  r_row [3];
    logic [23:0]  r_fx, r_fy, r_cx, r_cy;
    logic [13:0]  r_wid, r_hgt;
    logic         r_cam;

    logic         w_adv;
    logic signed [15:0] w_pin [3];

    logic               r_v1, r_lid1;
    logic signed [31:0] r_p1 [3][3];
    logic               r_v2, r_lid2;
    logic signed [C_W-1:0] r_c2 [3];
    logic               r_v3, r_lid3;
    logic signed [M_W-1:0] r_mu3, r_mcu3, r_mv3, r_mcv3;
    logic [32:0]        r_cz3;
    logic [21:0]        r_n3;
    logic               r_nz3, r_red3, r_half3;
    logic               r_v4, r_lid4;
    logic signed [N_W-1:0] r_nu4, r_nv4;
    logic [D_W-1:0]     r_dn4;
    logic [44:0]        r_pr4;
    logic [21:0]        r_n4;
    logic               r_nz4, r_red4, r_half4;

    logic [Z_W-1:0]     w_z;
    logic [35:0]        w_a;
    logic [9:0]         w_q0;
    logic [13:0]        w_rem0;
    logic [9:0]         w_q;
    logic               w_nz;
    t_col               w_col;
    logic               w_oku, w_okv;

    logic               r_dv  [PIX_W+1];
    logic               r_oku [PIX_W+1];
    logic               r_okv [PIX_W+1];
    logic [R_W-1:0]     r_ru  [PIX_W+1];
    logic [R_W-1:0]     r_rv  [PIX_W+1];
    logic [PIX_W-1:0]   r_qu  [PIX_W+1];
    logic [PIX_W-1:0]   r_qv  [PIX_W+1];
    logic [D_W-1:0]     r_dn  [PIX_W+1];
    t_col               r_col [PIX_W+1];

    logic               r_ov;
    logic [PIX_W-1:0]   r_ou, r_ovv;
    t_col               r_ocol;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= '0;
            r_row[1] <= '0;
            r_row[2] <= '0;
            r_fx     <= '0;
            r_fy     <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_wid    <= 14'd1600;
            r_hgt    <= 14'd900;
            r_cam    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROW_X:     r_row[0] <= i_cfg.data;
                REG_ROW_Y:     r_row[1] <= i_cfg.data;
                REG_ROW_Z:     r_row[2] <= i_cfg.data;
                REG_FOCAL: begin
                    r_fx <= i_cfg.data[23:0];
                    r_fy <= i_cfg.data[47:24];
                end
                REG_PRINCIPAL: begin
                    r_cx <= i_cfg.data[23:0];
                    r_cy <= i_cfg.data[47:24];
                end
                REG_WIDTH:     r_wid <= i_cfg.data[13:0];
                REG_HEIGHT:    r_hgt <= i_cfg.data[13:0];
                REG_CAM_READY: r_cam <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_adv       = !r_ov || o_px.ready;
    assign i_pt.ready  = w_adv;
    assign w_pin[0]    = i_pt.point_x;
    assign w_pin[1]    = i_pt.point_y;
    assign w_pin[2]    = i_pt.point_z;

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_pt.valid && r_cam && !(i_pt.from_lidar && (i_pt.point_z < Z_FLOOR));
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lid1 <= i_pt.from_lidar;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p1[i][j] <= $signed(r_row[i][16*j +: 16]) * w_pin[j];
                end
            end
        end
    end

    // stage 2: camera coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lid2 <= r_lid1;
            for (int i = 0; i < 3; i++) begin
                r_c2[i] <= C_W'(r_p1[i][0]) + C_W'(r_p1[i][1]) + C_W'(r_p1[i][2])
                         + $signed({{4{r_row[i][63]}}, r_row[i][63:48], 14'b0});
            end
        end
    end

    // stage 3: projection products, depth ramp setup
    assign w_z = (r_c2[2] > $signed({7'b0, RAMP_DEPTH})) ? RAMP_DEPTH : r_c2[2][Z_W-1:0];
    assign w_a = 36'(w_z) * 36'd510;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2 && (r_c2[2] > NEAR_LIMIT);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lid3  <= r_lid2;
            r_mu3   <= $signed({1'b0, r_fx}) * r_c2[0];
            r_mcu3  <= $signed({1'b0, r_cx}) * r_c2[2];
            r_mv3   <= $signed({1'b0, r_fy}) * r_c2[1];
            r_mcv3  <= $signed({1'b0, r_cy}) * r_c2[2];
            r_cz3   <= r_c2[2][32:0];
            r_n3    <= w_a[35:14];
            r_nz3   <= |w_a[13:0];
            r_red3  <= (31'(w_z) * 31'd10) < 31'(RAMP_DEPTH);
            r_half3 <= {w_z, 1'b0} < {1'b0, RAMP_DEPTH};
        end
    end

    // stage 4: numerators, divisor, reciprocal product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lid4  <= r_lid3;
            r_nu4   <= N_W'(r_mu3) + N_W'(r_mcu3);
            r_nv4   <= N_W'(r_mv3) + N_W'(r_mcv3);
            r_dn4   <= {r_cz3, 8'b0};
            r_pr4   <= 45'(r_n3) * 45'(RECIP_6000);
            r_n4    <= r_n3;
            r_nz4   <= r_nz3;
            r_red4  <= r_red3;
            r_half4 <= r_half3;
        end
    end

    // stage 5: range checks and dot colour
    assign w_q0   = r_pr4[44:35];
    assign w_rem0 = 14'(r_n4 - 22'(w_q0 * DIV_6000));
    assign w_q    = (w_rem0 >= 14'(DIV_6000)) ? w_q0 + 10'd1 : w_q0;
    assign w_nz   = r_nz4 || ((w_rem0 != 14'd0) && (w_rem0 != 14'(DIV_6000)));

    assign w_oku = r_nu4[N_W-1] ? ((r_nu4 + $signed({19'b0, r_dn4})) > 60'sd0)
                                : (r_nu4 < $signed({6'b0, r_dn4, 13'b0}));
    assign w_okv = r_nv4[N_W-1] ? ((r_nv4 + $signed({19'b0, r_dn4})) > 60'sd0)
                                : (r_nv4 < $signed({6'b0, r_dn4, 13'b0}));

    always_comb begin
        w_col.radius = r_lid4 ? RADIUS_LIDAR : RADIUS_RADAR;
        if (!r_lid4 || r_red4) begin
            w_col.blue  = 8'd0;
            w_col.green = 8'd0;
            w_col.red   = 8'd255;
        end else if (r_half4) begin
            w_col.blue  = 8'd0;
            w_col.green = w_q[7:0];
            w_col.red   = 8'(10'd255 - w_q - 10'(w_nz));
        end else begin
            w_col.blue  = 8'(w_q - 10'd255);
            w_col.green = 8'(10'd510 - w_q - 10'(w_nz));
            w_col.red   = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv[0] <= r_v4;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oku[0] <= w_oku;
            r_okv[0] <= w_okv;
            r_ru[0]  <= r_nu4[N_W-1] ? '0 : r_nu4[R_W-1:0];
            r_rv[0]  <= r_nv4[N_W-1] ? '0 : r_nv4[R_W-1:0];
            r_qu[0]  <= '0;
            r_qv[0]  <= '0;
            r_dn[0]  <= r_dn4;
            r_col[0] <= w_col;
        end
    end

    // divider: one quotient bit per stage, most significant first
    for (genvar s = 0; s < PIX_W; s++) begin : g_div
        logic [R_W-1:0] w_dsh;
        logic [R_W:0]   n_tu, n_tv;

        assign w_dsh = R_W'(r_dn[s]) << (PIX_W - 1 - s);
        assign n_tu  = {1'b0, r_ru[s]} - {1'b0, w_dsh};
        assign n_tv  = {1'b0, r_rv[s]} - {1'b0, w_dsh};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[s+1] <= r_dv[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_oku[s+1] <= r_oku[s];
                r_okv[s+1] <= r_okv[s];
                r_ru[s+1]  <= n_tu[R_W] ? r_ru[s] : n_tu[R_W-1:0];
                r_rv[s+1]  <= n_tv[R_W] ? r_rv[s] : n_tv[R_W-1:0];
                r_qu[s+1]  <= {r_qu[s][PIX_W-2:0], !n_tu[R_W]};
                r_qv[s+1]  <= {r_qv[s][PIX_W-2:0], !n_tv[R_W]};
                r_dn[s+1]  <= r_dn[s];
                r_col[s+1] <= r_col[s];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_dv[PIX_W] && r_oku[PIX_W] && r_okv[PIX_W]
                 && (14'(r_qu[PIX_W]) < r_wid) && (14'(r_qv[PIX_W]) < r_hgt);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ou   <= r_qu[PIX_W];
            r_ovv  <= r_qv[PIX_W];
            r_ocol <= r_col[PIX_W];
        end
    end

    assign o_px.valid      = r_ov;
    assign o_px.pixel_u    = r_ou;
    assign o_px.pixel_v    = r_ovv;
    assign o_px.blue       = r_ocol.blue;
    assign o_px.green      = r_ocol.green;
    assign o_px.red        = r_ocol.red;
    assign o_px.dot_radius = r_ocol.radius;

endmodule

>>> sv/pcp_check.sv
// Port checker for the point camera projector and its bind
`include "point_camera_projector_assert.svh"

module pcp_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [12:0] i_pixel_u,
    input logic [12:0] i_pixel_v,
    input logic [7:0]  i_blue,
    input logic [7:0]  i_green,
    input logic [7:0]  i_red,
    input logic [2:0]  i_dot_radius
);
    import pcp_pkg::*;

    logic [52:0] w_payload;
    logic        w_radius_ok;
    logic        w_red_only;
    logic        w_one_zero;

    assign w_payload   = {i_pixel_u, i_pixel_v, i_blue, i_green, i_red, i_dot_radius};
    assign w_radius_ok = (i_dot_radius == RADIUS_LIDAR) || (i_dot_radius == RADIUS_RADAR);
    assign w_red_only  = (i_red == 8'd255) && (i_green == 8'd0) && (i_blue == 8'd0);
    assign w_one_zero  = (i_red == 8'd0) || (i_blue == 8'd0);

    `PCP_ASSERT_NEXT(a_hold, i_valid && !i_ready, i_valid && $stable(w_payload))
    `PCP_ASSERT_NOW(a_radius, i_valid, w_radius_ok)
    `PCP_ASSERT_NOW(a_radar_red, i_valid && (i_dot_radius == RADIUS_RADAR), w_red_only)
    `PCP_ASSERT_NOW(a_ramp, i_valid && (i_dot_radius == RADIUS_LIDAR), w_one_zero)

endmodule

bind point_camera_projector pcp_check u_pcp_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_px.valid),
    .i_ready      (o_px.ready),
    .i_pixel_u    (o_px.pixel_u),
    .i_pixel_v    (o_px.pixel_v),
    .i_blue       (o_px.blue),
    .i_green      (o_px.green),
    .i_red        (o_px.red),
    .i_dot_radius (o_px.dot_radius)
);

>>> tb/pcp_checker.sv
// Checker for the point camera projector: pixel prediction and comparison
`timescale 1ns / 1ps
module pcp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    pcp_pt_if    i_pt,
    pcp_px_if    i_px,
    pcp_cfg_if   i_cfg,
    output int   o_failures,
    output int   o_pending,
    output int   o_checked
);
    import pcp_pkg::*;

    typedef struct packed {
        logic [12:0] u;
        logic [12:0] v;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [2:0]  radius;
    } t_pixel;

    logic [63:0] row_x, row_y, row_z;
    logic [47:0] focal, principal;
    logic [13:0] width, height;
    logic        cam_ready;
    t_pixel      pixel_q[$];

    function automatic longint q14(input logic [15:0] f);
        return longint'($signed(f));
    endfunction

    function automatic longint to_camera(input logic [63:0] row, input longint x,
                                         input longint y, input longint z);
        return q14(row[15:0]) * x + q14(row[31:16]) * y + q14(row[47:32]) * z
             + q14(row[63:48]) * 16384;
    endfunction

    function automatic bit project_point(input logic signed [15:0] px,
                                         input logic signed [15:0] py,
                                         input logic signed [15:0] pz,
                                         input logic lidar, output t_pixel res);
        longint x, y, z, cx, cy, cz, u, v, wl, hl, zz, dd;
        x = px;
        y = py;
        z = pz;
        dd = 64'd98304000;
        res = '0;
        if (!cam_ready) return 0;
        if (lidar && z < -150) return 0;
        cx = to_camera(row_x, x, y, z);
        cy = to_camera(row_y, x, y, z);
        cz = to_camera(row_z, x, y, z);
        if (cz <= 163840) return 0;
        u = (longint'(focal[23:0]) * cx + longint'(principal[23:0]) * cz) / (256 * cz);
        v = (longint'(focal[47:24]) * cy + longint'(principal[47:24]) * cz) / (256 * cz);
        wl = (width > 14'd8192) ? 8192 : longint'(width);
        hl = (height > 14'd8192) ? 8192 : longint'(height);
        if (u < 0 || u >= wl || v < 0 || v >= hl) return 0;
        res.u = u[12:0];
        res.v = v[12:0];
        res.red = 8'd255;
        res.radius = lidar ? RADIUS_LIDAR : RADIUS_RADAR;
        if (lidar) begin
            zz = (cz > dd) ? dd : cz;
            if (10 * zz < dd) begin
                res.red = 8'd255;
            end else if (2 * zz < dd) begin
                res.green = 8'((510 * zz) / dd);
                res.red = 8'((255 * (dd - 2 * zz)) / dd);
            end else begin
                res.blue = 8'((255 * (2 * zz - dd)) / dd);
                res.green = 8'((255 * (2 * dd - 2 * zz)) / dd);
                res.red = 8'd0;
            end
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want, got;
        if (!i_rst_n) begin
            row_x = '0;
            row_y = '0;
            row_z = '0;
            focal = '0;
            principal = '0;
            width = 14'd1600;
            height = 14'd900;
            cam_ready = 1'b0;
        end else begin
            if (i_px.valid && i_px.ready) begin
                got = {i_px.pixel_u, i_px.pixel_v, i_px.blue, i_px.green, i_px.red,
                       i_px.dot_radius};
                o_checked++;
                if (pixel_q.size() == 0) begin
                    o_failures++;
                    if (o_failures <= 10)
                        $display("%0t: unexpected pixel item %p", $realtime, got);
                end else begin
                    want = pixel_q.pop_front();
                    if (got !== want) begin
                        o_failures++;
                        if (o_failures <= 10)
                            $display("%0t: pixel mismatch expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (i_pt.valid && i_pt.ready) begin
                if (project_point(i_pt.point_x, i_pt.point_y, i_pt.point_z,
                                  i_pt.from_lidar, want))
                    pixel_q.push_back(want);
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_ROW_X:     row_x = i_cfg.data;
                    REG_ROW_Y:     row_y = i_cfg.data;
                    REG_ROW_Z:     row_z = i_cfg.data;
                    REG_FOCAL:     focal = i_cfg.data[47:0];
                    REG_PRINCIPAL: principal = i_cfg.data[47:0];
                    REG_WIDTH:     width = i_cfg.data[13:0];
                    REG_HEIGHT:    height = i_cfg.data[13:0];
                    REG_CAM_READY: cam_ready = i_cfg.data[0];
                    default: ;
                endcase
            end
        end
        o_pending = pixel_q.size();
    end

    initial begin
        o_failures = 0;
        o_pending = 0;
        o_checked = 0;
    end
endmodule

>>> tb/testbench.sv
// Top of the point camera projector testbench: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module testbench;
    import pcp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;
    int   failures, pending, checked;
    int   points_sent, quiet_cycles;
    bit   idle_on, hold_req;

    pcp_pt_if  pt ();
    pcp_px_if  px ();
    pcp_cfg_if cfg ();

    point_camera_projector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .o_px    (px),
        .i_cfg   (cfg)
    );

    pcp_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt       (pt),
        .i_px       (px),
        .i_cfg      (cfg),
        .o_failures (failures),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (pt.valid && pt.ready) || (px.valid && px.ready)
                || (cfg.valid && cfg.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d pixel items outstanding", pending);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        px.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                px.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                px.ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge i_clk);
            end else begin
                px.ready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] pack_row(input int r0, input int r1, input int r2,
                                             input int t);
        return {t[15:0], r2[15:0], r1[15:0], r0[15:0]};
    endfunction

    function automatic int rand_signed(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_point(input int x, input int y, input int z, input bit lidar);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            pt.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pt.valid      <= 1'b1;
        pt.point_x    <= x[15:0];
        pt.point_y    <= y[15:0];
        pt.point_z    <= z[15:0];
        pt.from_lidar <= lidar;
        do @(posedge i_clk); while (!pt.ready);
        @(negedge i_clk);
        points_sent++;
    endtask

    task automatic drain();
        pt.valid <= 1'b0;
        wait (pending == 0);
        repeat (30) @(negedge i_clk);
    endtask

    // sensor x forward, y left, z up; camera 20 cm ahead, 50 cm above
    task automatic load_vehicle_setup(input int f, input int w, input int h);
        write_reg(REG_ROW_X, pack_row(0, -16384, 0, 0));
        write_reg(REG_ROW_Y, pack_row(0, 0, -16384, 50));
        write_reg(REG_ROW_Z, pack_row(16384, 0, 0, -20));
        write_reg(REG_FOCAL, 64'({24'(f), 24'(f)}));
        write_reg(REG_PRINCIPAL, 64'({24'(h * 128), 24'(w * 128)}));
        write_reg(REG_WIDTH, 64'(w));
        write_reg(REG_HEIGHT, 64'(h));
    endtask

    task automatic send_road_points(input int n);
        int x;
        repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
                send_point(rand_signed(32768), rand_signed(32768), rand_signed(32768),
                           1'($urandom_range(0, 1)));
            end else begin
                x = $urandom_range(25, 8000);
                send_point(x, rand_signed(x), rand_signed(x / 2) - 100,
                           $urandom_range(0, 3) != 0);
            end
        end
    endtask

    initial begin
        idle_on = 1'b1;
        hold_req = 1'b0;
        points_sent = 0;
        quiet_cycles = 0;
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_z = '0;
        pt.from_lidar = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // camera not ready: nothing comes out
        send_point(1000, 0, 0, 1);
        send_point(-32768, 32767, -32768, 0);
        send_point(32767, -32768, 32767, 1);
        drain();

        load_vehicle_setup(256128, 1600, 900);
        write_reg(REG_UNUSED, '1);
        write_reg(REG_CAM_READY, 64'd1);
        send_point(1000, 0, 0, 1);
        send_point(1000, 0, 0, 0);
        send_point(1000, 0, -151, 1);
        send_point(1000, 0, -150, 1);
        send_point(1000, 0, -151, 0);
        send_point(30, 0, 0, 1);
        send_point(31, 0, 0, 1);
        send_point(620, 0, 0, 1);
        send_point(3020, 0, 0, 1);
        send_point(6020, 0, 0, 1);
        send_point(9000, 0, 0, 1);
        send_point(32767, 0, 0, 1);
        send_point(-32768, 0, 0, 0);
        send_point(32767, 32767, 0, 1);
        send_point(32767, -32768, 0, 1);
        send_point(32767, 0, 32767, 0);
        send_point(32767, 0, -32768, 0);
        send_point(1000, 800, 0, 1);
        send_point(1000, -799, 0, 1);
        send_point(1000, 0, 450, 1);
        send_point(1000, 0, -449, 0);
        send_point(1000, 1, 0, 0);
        drain();

        hold_req = 1'b1;
        send_road_points(200);
        drain();

        write_reg(REG_ROW_X, pack_row(16384, 0, 0, 0));
        write_reg(REG_ROW_Y, pack_row(0, 16384, 0, 0));
        write_reg(REG_ROW_Z, pack_row(0, 0, 32767, -32768));
        write_reg(REG_FOCAL, 64'(48'hFFFFFF_FFFFFF));
        write_reg(REG_PRINCIPAL, 64'(48'hFFFFFF_000000));
        write_reg(REG_WIDTH, 64'd16383);
        write_reg(REG_HEIGHT, 64'd8192);
        repeat (100)
            send_point(rand_signed(32768), rand_signed(32768),
                       $urandom_range(0, 32767), 1'($urandom_range(0, 1)));
        drain();

        write_reg(REG_ROW_X, {$urandom, $urandom});
        write_reg(REG_ROW_Y, {$urandom, $urandom});
        write_reg(REG_ROW_Z, {$urandom, $urandom});
        write_reg(REG_FOCAL, {$urandom, $urandom});
        write_reg(REG_PRINCIPAL, {$urandom, $urandom});
        write_reg(REG_WIDTH, 64'($urandom_range(0, 16383)));
        write_reg(REG_HEIGHT, 64'($urandom_range(0, 16383)));
        repeat (60)
            send_point(rand_signed(32768), rand_signed(32768), rand_signed(32768),
                       1'($urandom_range(0, 1)));
        drain();

        load_vehicle_setup(128000, 800, 450);
        write_reg(REG_WIDTH, 64'd0);
        send_road_points(20);
        drain();
        write_reg(REG_WIDTH, 64'd800);
        write_reg(REG_HEIGHT, 64'd0);
        send_road_points(20);
        drain();
        write_reg(REG_CAM_READY, 64'd0);
        send_road_points(10);
        drain();

        load_vehicle_setup(204800, 1280, 720);
        write_reg(REG_CAM_READY, 64'd1);
        send_road_points(80);
        idle_on = 1'b0;
        send_road_points(120);
        drain();

        $display("sent %0d points over eight register settings, checked %0d pixel items",
                 points_sent, checked);
        $display("covered height filter, near plane, image edges and depth colour ramp");
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", failures);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+sv
sv/pcp_pkg.sv
sv/pcp_if.sv
sv/point_camera_projector.sv
sv/pcp_check.sv
tb/pcp_checker.sv
tb/testbench.sv
